>>> rtl/core/ehash_pkg.sv
// Shared types, widths and the byte-mixing function of the ELF hash core.
package ehash_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HASH_W = 28;
  localparam int unsigned BKT_W  = 16;
  localparam int unsigned STEP_W = 5;

  localparam logic [BKT_W-1:0]  BUCKET_COUNT_RESET = 16'd256;
  localparam logic [STEP_W-1:0] DIV_STEPS          = 5'd28;

  typedef logic [BYTE_W-1:0] byte_val_t;
  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [BKT_W-1:0]  bkt_t;

  // Finished key hash handed from the front to the queue.
  typedef struct packed {
    logic  push;
    hash_t hash;
  } push_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic  avail;
    hash_t hash;
  } head_t;

  // Shift in one byte in 32-bit arithmetic, fold the top nibble in at bit 4, drop it.
  function automatic hash_t mix_byte(hash_t h, byte_val_t b);
    logic [31:0] t;
    logic [3:0]  top;
    hash_t       r;
    t   = {h, 4'b0000} + {24'd0, b};
    top = t[31:28];
    r   = t[27:0];
    r[7:4] = r[7:4] ^ top;
    return r;
  endfunction

endpackage

>>> rtl/core/ehash_front.sv
// Front end: accepts key bytes and keeps the running ELF hash.
module ehash_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ehash_pkg::byte_val_t in_key_byte,
  input  logic                in_key_last,
  input  logic                q_full,
  output logic                in_ready,
  output ehash_pkg::push_t    push
);
  import ehash_pkg::*;

  hash_t hash_r;
  hash_t hash_nxt;
  hash_t mixed;
  logic  accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign mixed    = mix_byte(hash_r, in_key_byte);

  always_comb begin
    hash_nxt = hash_r;
    if (accept) begin
      hash_nxt = in_key_last ? '0 : mixed;
    end
  end

  assign push.push = accept && in_key_last;
  assign push.hash = mixed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

>>> rtl/core/ehash_queue.sv
// Short FIFO of finished key hashes between front and back end.
module ehash_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ehash_pkg::push_t push,
  input  logic             pop,
  output ehash_pkg::head_t head,
  output logic             full
);
  import ehash_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  hash_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head.avail = (cnt_r != '0);
  assign head.hash  = mem[rd_ptr_r];
  assign do_push    = push.push && !full;
  assign do_pop     = pop && head.avail;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.hash;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.push |-> !full)
    else $error("queue push while full");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count overflow");

  a_pop_moves_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && DEPTH > 1) |=> (rd_ptr_r != $past(rd_ptr_r)))
    else $error("pop did not advance read pointer");

endmodule

>>> rtl/core/ehash_back.sv
// Back end: bit-serial modulo of each key hash and the result output register.
module ehash_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ehash_pkg::head_t head,
  input  ehash_pkg::bkt_t  bucket_count,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output ehash_pkg::bkt_t  out_bucket_index,
  output ehash_pkg::hash_t out_hash_value
);
  import ehash_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  hash_t             dvd_r, dvd_nxt;
  hash_t             hash_r, hash_nxt;
  bkt_t              rem_r, rem_nxt;
  bkt_t              div_r, div_nxt;
  logic              out_valid_r, out_valid_nxt;
  bkt_t              out_bkt_r, out_bkt_nxt;
  hash_t             out_hash_r, out_hash_nxt;
  logic [BKT_W:0]    trial;
  logic              slot_free;

  assign trial     = {rem_r, dvd_r[HASH_W-1]};
  assign slot_free = !out_valid_r || out_ready;
  assign pop       = (state_r == ST_IDLE) && head.avail;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    dvd_nxt       = dvd_r;
    hash_nxt      = hash_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    out_valid_nxt = out_valid_r;
    out_bkt_nxt   = out_bkt_r;
    out_hash_nxt  = out_hash_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (head.avail) begin
          dvd_nxt   = head.hash;
          hash_nxt  = head.hash;
          rem_nxt   = '0;
          div_nxt   = bucket_count;
          cnt_nxt   = DIV_STEPS;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // restoring step: shift in one dividend bit, subtract if it fits
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = BKT_W'(trial - {1'b0, div_r});
        end else begin
          rem_nxt = trial[BKT_W-1:0];
        end
        dvd_nxt = {dvd_r[HASH_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_bkt_nxt   = (div_r == '0) ? '0 : rem_r;
          out_hash_nxt  = hash_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dvd_r      <= dvd_nxt;
    hash_r     <= hash_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    cnt_r      <= cnt_nxt;
    out_bkt_r  <= out_bkt_nxt;
    out_hash_r <= out_hash_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bucket_index = out_bkt_r;
  assign out_hash_value   = out_hash_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && div_r != '0) |-> (rem_r < div_r))
    else $error("partial remainder not below divisor");

  a_run_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r != '0))
    else $error("divider running with zero step count");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && out_valid_r && !out_ready) |=> (state_r == ST_HOLD))
    else $error("result dropped while output stalled");

  a_start_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == ST_RUN && cnt_r == DIV_STEPS))
    else $error("divider did not start after pop");

endmodule

>>> rtl/core/elf_string_hash_bucket_index_core.sv
// Top level of the PJW/ELF string hash core with bucket selection.
//
// Usage: stream a key one byte per transaction on the in_ channel, with
// in_key_last high on the final byte. Bytes are hashed as unsigned values;
// the running hash lives in the front end and advances one byte per cycle
// while in_ready is high. On the final byte the finished hash drops into a
// short queue and the running hash clears for the next key.
// The back end pops one hash at a time and reduces it modulo the bucket
// count with a bit-serial restoring divider, one dividend bit per cycle.
// From the last byte to out_valid the hash passes the queue, the pop, 28
// divide steps and the load of the output register. Throughput: one byte
// per cycle while in_ready is high; the next hash is popped only once the
// last result is loaded, so short keys fill the queue and then stall in_ready.
// A bucket count of zero yields a bucket index of zero.
// When the receiver holds out_ready low, the result waits in the output
// register, the divider holds its finished remainder, and the queue keeps
// taking keys until full; then in_ready drops.
// cfg_we writes cfg_bucket_count into a register; write it only while idle.
// Reset (rst_n low, synchronous) clears the hash, the queue, the output
// valid and sets the bucket count to 256.
module elf_string_hash_bucket_index_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ehash_pkg::byte_val_t in_key_byte,
  input  logic                 in_key_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ehash_pkg::bkt_t      out_bucket_index,
  output ehash_pkg::hash_t     out_hash_value,
  input  logic                 cfg_we,
  input  ehash_pkg::bkt_t      cfg_bucket_count
);
  import ehash_pkg::*;

  bkt_t  bucket_count_r;
  push_t push;
  head_t head;
  logic  q_full;
  logic  pop;

  // Hold the divisor; take a new value on each write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BUCKET_COUNT_RESET;
    end else if (cfg_we) begin
      bucket_count_r <= cfg_bucket_count;
    end
  end

  // Front: byte accept and running hash.
  ehash_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_key_byte (in_key_byte),
    .in_key_last (in_key_last),
    .q_full      (q_full),
    .in_ready    (in_ready),
    .push        (push)
  );

  // Decouple the byte stream from the slow modulo.
  ehash_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  // Back: modulo and result register.
  ehash_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .bucket_count     (bucket_count_r),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bucket_index (out_bucket_index),
    .out_hash_value   (out_hash_value)
  );

endmodule
